// ===== design/fbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Fixed block pool allocator package
// Shared constants, request and status codes, and the stack control type.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int MAX_BUFFERS      = 256;
    localparam int HEADER_BYTES_DEF = 4;

    localparam int IDX_W    = $clog2(MAX_BUFFERS);
    localparam int DEPTH_W  = $clog2(MAX_BUFFERS + 1);
    localparam int BYTES_W  = 16;
    localparam int COUNT_W  = 9;
    localparam int OFFSET_W = 24;
    localparam int FREE_W   = 9;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [REQ_W-1:0] REQ_GET    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RETURN = 2'd1;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_HELD = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_INVALID  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_BYTES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_COUNT = 1'd1;

    typedef struct packed {
        logic push;
        logic pop;
    } fbpa_stack_ctl_t;

endpackage

// ===== design/fbpa_stack_cell.sv =====
// ----------------------------------------------------------------------------
// Free list stack cell
// One entry of the shifting stack; takes its neighbour's entry on push or pop.
// ----------------------------------------------------------------------------
module fbpa_stack_cell
    import fbpa_pkg::*;
(
    input  logic                 aclk,
    input  fbpa_stack_ctl_t      ctl,
    input  logic [IDX_W-1:0]     from_prev,
    input  logic [IDX_W-1:0]     from_next,
    output logic [IDX_W-1:0]     entry
);

    logic [IDX_W-1:0] entry_reg;
    logic [IDX_W-1:0] entry_next;

    always_comb begin
        priority if (ctl.push) begin
            entry_next = from_prev;
        end else if (ctl.pop) begin
            entry_next = from_next;
        end else begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== design/fbpa_stack.sv =====
// ----------------------------------------------------------------------------
// Free list stack
// A row of cells; the top sits in cell zero and every cell shifts together.
// ----------------------------------------------------------------------------
module fbpa_stack
    import fbpa_pkg::*;
(
    input  logic                 aclk,
    input  fbpa_stack_ctl_t      ctl,
    input  logic [IDX_W-1:0]     push_data,
    output logic [IDX_W-1:0]     top
);

    logic [IDX_W-1:0] entries [MAX_BUFFERS];

    for (genvar i = 0; i < MAX_BUFFERS; i++) begin : g_cell
        logic [IDX_W-1:0] prev_val;
        logic [IDX_W-1:0] next_val;

        if (i == 0) begin : g_first
            assign prev_val = push_data;
        end else begin : g_mid_prev
            assign prev_val = entries[i-1];
        end

        if (i == MAX_BUFFERS - 1) begin : g_last
            assign next_val = '0;
        end else begin : g_mid_next
            assign next_val = entries[i+1];
        end

        fbpa_stack_cell u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .from_prev (prev_val),
            .from_next (next_val),
            .entry     (entries[i])
        );
    end

    assign top = entries[0];

endmodule

// ===== design/fbpa_offset.sv =====
// ----------------------------------------------------------------------------
// Payload offset
// Index times the buffer stride plus the header, saturated to the field width.
// ----------------------------------------------------------------------------
module fbpa_offset
    import fbpa_pkg::*;
#(
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic [IDX_W-1:0]    index,
    input  logic [BYTES_W-1:0]  buffer_bytes,
    output logic [OFFSET_W-1:0] offset
);

    localparam int STRIDE_W = BYTES_W + 1;
    localparam int PROD_W   = STRIDE_W + IDX_W;
    localparam int SUM_W    = PROD_W + 1;

    logic [STRIDE_W-1:0] stride;
    logic [PROD_W-1:0]   product;
    logic [SUM_W-1:0]    sum;

    always_comb begin
        stride  = {1'b0, buffer_bytes} + STRIDE_W'(HEADER_BYTES);
        product = PROD_W'(stride) * PROD_W'(index);
        sum     = {1'b0, product} + SUM_W'(HEADER_BYTES);
        if (sum > SUM_W'({OFFSET_W{1'b1}})) begin
            offset = {OFFSET_W{1'b1}};
        end else begin
            offset = sum[OFFSET_W-1:0];
        end
    end

endmodule

// ===== design/fixed_block_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// Fixed block pool allocator
// Hands out and takes back fixed-size buffers through a last-in-first-out
// free list, with never-used buffers issued in ascending order.
// ----------------------------------------------------------------------------
//  Channel   Direction  Ports
//  s_        in         s_valid s_ready s_req_type s_buf_index
//  m_        out        m_valid m_ready m_status m_granted_index
//                       m_granted_offset m_free_count
//  cfg_      in         cfg_valid cfg_ready cfg_index cfg_data
//
// Each request is served combinationally and its result is registered, so a
// transfer may be accepted on every cycle while the result is taken.
// The free list is a row of shifting cells, so a push or pop completes at once.
// A stalled result holds the input side off until it is taken.
// Reset and any register write free every buffer; no clearing pass is needed.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator
    import fbpa_pkg::*;
#(
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [REQ_W-1:0]      s_req_type,
    input  logic [IDX_W-1:0]      s_buf_index,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic [IDX_W-1:0]      m_granted_index,
    output logic [OFFSET_W-1:0]   m_granted_offset,
    output logic [FREE_W-1:0]     m_free_count,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [BYTES_W-1:0]    cfg_data
);

    localparam logic [DEPTH_W-1:0] MAX_DEPTH = DEPTH_W'(MAX_BUFFERS);

    logic [BYTES_W-1:0]     buffer_bytes_reg;
    logic [COUNT_W-1:0]     buffer_count_reg;
    logic [DEPTH_W-1:0]     depth_reg, depth_next;
    logic [DEPTH_W-1:0]     fresh_reg, fresh_next;
    logic [MAX_BUFFERS-1:0] in_use_reg, in_use_next;

    logic                   m_valid_reg;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [IDX_W-1:0]       grant_reg, grant_next;
    logic [OFFSET_W-1:0]    offset_reg, offset_next;
    logic [FREE_W-1:0]      free_reg, free_next;

    logic                   s_fire;
    logic                   cfg_fire;
    logic [DEPTH_W-1:0]     cnt_eff;
    logic                   pool_valid;
    logic                   grant_ok;
    logic [IDX_W-1:0]       stack_top;
    logic [OFFSET_W-1:0]    offset_calc;
    logic [DEPTH_W-1:0]     fresh_left;
    logic [DEPTH_W:0]       free_total;
    fbpa_stack_ctl_t        stack_ctl;

    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    assign cnt_eff    = (buffer_count_reg > COUNT_W'(MAX_BUFFERS)) ? MAX_DEPTH
                                                                   : DEPTH_W'(buffer_count_reg);
    assign pool_valid = (buffer_bytes_reg != '0) && (cnt_eff != '0);

    fbpa_stack u_stack (
        .aclk      (aclk),
        .ctl       (stack_ctl),
        .push_data (s_buf_index),
        .top       (stack_top)
    );

    fbpa_offset #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_offset (
        .index        (grant_next),
        .buffer_bytes (buffer_bytes_reg),
        .offset       (offset_calc)
    );

    always_comb begin
        depth_next     = depth_reg;
        fresh_next     = fresh_reg;
        in_use_next    = in_use_reg;
        status_next    = STATUS_OK;
        grant_next     = '0;
        grant_ok       = 1'b0;
        stack_ctl.push = 1'b0;
        stack_ctl.pop  = 1'b0;
        if (s_fire) begin
            if (s_req_type == REQ_GET) begin
                if (!pool_valid) begin
                    status_next = STATUS_INVALID;
                end else if (depth_reg != '0) begin
                    grant_ok      = 1'b1;
                    grant_next    = stack_top;
                    stack_ctl.pop = 1'b1;
                    depth_next    = depth_reg - 1'b1;
                end else if (fresh_reg < cnt_eff) begin
                    grant_ok   = 1'b1;
                    grant_next = fresh_reg[IDX_W-1:0];
                    fresh_next = fresh_reg + 1'b1;
                end else begin
                    status_next = STATUS_EMPTY;
                end
                if (grant_ok) begin
                    in_use_next[grant_next] = 1'b1;
                end
            end else if (s_req_type == REQ_RETURN) begin
                if (!pool_valid) begin
                    status_next = STATUS_INVALID;
                end else if ((DEPTH_W'(s_buf_index) >= cnt_eff) || !in_use_reg[s_buf_index]
                             || (depth_reg >= MAX_DEPTH)) begin
                    status_next = STATUS_NOT_HELD;
                end else begin
                    in_use_next[s_buf_index] = 1'b0;
                    stack_ctl.push           = 1'b1;
                    depth_next               = depth_reg + 1'b1;
                end
            end
        end

        offset_next = grant_ok ? offset_calc : '0;
        fresh_left  = (fresh_next < cnt_eff) ? (cnt_eff - fresh_next) : '0;
        free_total  = {1'b0, fresh_left} + {1'b0, depth_next};
        if (!pool_valid) begin
            free_next = '0;
        end else if (free_total > (DEPTH_W + 1)'({FREE_W{1'b1}})) begin
            free_next = {FREE_W{1'b1}};
        end else begin
            free_next = FREE_W'(free_total);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buffer_bytes_reg <= BYTES_W'(64);
            buffer_count_reg <= COUNT_W'(256);
            depth_reg        <= '0;
            fresh_reg        <= '0;
            in_use_reg       <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_fire) begin
                unique case (cfg_index)
                    CFG_BUFFER_BYTES: buffer_bytes_reg <= cfg_data;
                    CFG_BUFFER_COUNT: buffer_count_reg <= cfg_data[COUNT_W-1:0];
                    default:          buffer_bytes_reg <= buffer_bytes_reg;
                endcase
                depth_reg  <= '0;
                fresh_reg  <= '0;
                in_use_reg <= '0;
            end else begin
                depth_reg  <= depth_next;
                fresh_reg  <= fresh_next;
                in_use_reg <= in_use_next;
            end
            if (s_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            status_reg <= status_next;
            grant_reg  <= grant_next;
            offset_reg <= offset_next;
            free_reg   <= free_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = status_reg;
    assign m_granted_index  = grant_reg;
    assign m_granted_offset = offset_reg;
    assign m_free_count     = free_reg;

    a_fail_no_grant : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (status_reg != STATUS_OK) |-> (grant_reg == '0) && (offset_reg == '0))
        else $error("A failed request carries a buffer grant.");

    a_depth_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= fresh_reg)
        else $error("More buffers returned than were ever handed out.");

    a_grant_marked : assert property (@(posedge aclk) disable iff (!aresetn)
        grant_ok && !cfg_fire |=> in_use_reg[$past(grant_next)])
        else $error("A granted buffer is not marked as allocated.");

endmodule
